/* src/truetype_simple_glyph_decoder_assert.svh */
// assertion macros used by the checker of the glyph decoder
`ifndef TRUETYPE_SIMPLE_GLYPH_DECODER_ASSERT_SVH
`define TRUETYPE_SIMPLE_GLYPH_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TSGD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define TSGD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/tsgd_pkg.sv */
package tsgd_pkg;

	// point capacity of the flag and x stores
	localparam int MAX_POINTS = 512;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int INDEX_W    = 9;
	localparam int HEADER_BYTES = 10;

	// simple glyph flag bits
	localparam logic [7:0] FLAG_X_SHORT = 8'h02;
	localparam logic [7:0] FLAG_Y_SHORT = 8'h04;
	localparam logic [7:0] FLAG_REPEAT  = 8'h08;
	localparam logic [7:0] FLAG_X_SAME  = 8'h10;
	localparam logic [7:0] FLAG_Y_SAME  = 8'h20;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_CONTOURS = 2'd1,
		ERR_POINTS   = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_HEADER = 4'd1,
		PH_ENDPTS = 4'd2,
		PH_INSLEN = 4'd3,
		PH_SKIP   = 4'd4,
		PH_FLAGS  = 4'd5,
		PH_COUNT  = 4'd6,
		PH_REPEAT = 4'd7,
		PH_XCOORD = 4'd8,
		PH_YCOORD = 4'd9
	} phase_t;

	typedef struct packed {
		logic               byte_taken;
		logic               point_valid;
		logic [INDEX_W-1:0] point_index;
		logic [15:0]        x_coord;
		logic [15:0]        y_coord;
		logic [7:0]         point_flag;
		logic               last_point;
		err_t               error_code;
		logic [15:0]        box_x_min;
		logic [15:0]        box_y_min;
		logic [15:0]        box_x_max;
		logic [15:0]        box_y_max;
	} result_t;

	typedef struct packed {
		logic             flag_we;
		logic             x_we;
		logic [IDX_W-1:0] waddr;
		logic [7:0]       flag_wdata;
		logic [15:0]      x_wdata;
		logic [IDX_W-1:0] raddr;
	} mem_ctl_t;

endpackage

/* src/tsgd_ram.sv */
module tsgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first read port
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/tsgd_parser.sv */
module tsgd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [7:0]         data_byte,
	input  logic               glyph_start,
	input  logic [7:0]         flag_rd,
	input  logic [15:0]        x_rd,
	output tsgd_pkg::result_t  res,
	output tsgd_pkg::mem_ctl_t mem
);

	localparam int CNT_W = tsgd_pkg::CNT_W;
	localparam int IDX_W = tsgd_pkg::IDX_W;

	tsgd_pkg::phase_t phase_q, ph_e, phase_d;
	logic [15:0]      fbc_q, fbc_e, fbc_d;
	logic [15:0]      contours_q, contours_d;
	logic [CNT_W-1:0] total_q, total_d;
	logic [15:0]      skip_q, skip_d;
	logic [7:0]       hold_q, hold_d;
	logic [7:0]       rep_q, rep_e, rep_d;
	logic [7:0]       rep_flag_q, rep_flag_d;
	logic [CNT_W-1:0] cursor_q, cur_e, cursor_d;
	logic [15:0]      xr_q, xr_e, xr_d;
	logic [15:0]      yr_q, yr_e, yr_d;
	logic [15:0]      box_q [4];
	logic [15:0]      box_d [4];

	logic [15:0]      word;
	logic [2:0]       hdr_idx;
	logic             hdr_bad;
	logic [16:0]      pts;
	logic             pts_bad;
	logic             endpts_last;
	logic [CNT_W-1:0] cur_inc;
	logic             cur_end;
	logic             is_y, sbit, same, need, first_long, done;
	logic [15:0]      acc, dval;
	logic             do_after;
	logic [CNT_W-1:0] af_cur;
	logic [7:0]       af_rep;

	// glyph start restarts the parse before the byte is handled
	always_comb begin
		ph_e  = phase_q;
		fbc_e = fbc_q;
		cur_e = cursor_q;
		rep_e = rep_q;
		xr_e  = xr_q;
		yr_e  = yr_q;
		if (glyph_start) begin
			ph_e  = tsgd_pkg::PH_HEADER;
			fbc_e = '0;
			cur_e = '0;
			rep_e = '0;
			xr_e  = '0;
			yr_e  = '0;
		end
	end

	// shared field decode
	always_comb begin
		word        = {hold_q, data_byte};
		hdr_idx     = fbc_e[3:1];
		hdr_bad     = fbc_e[0] && (hdr_idx == 3'd0) && ((word == 16'd0) || word[15]);
		pts         = {1'b0, word} + 17'd1;
		pts_bad     = pts > 17'(tsgd_pkg::MAX_POINTS);
		endpts_last = ({1'b0, fbc_e} + 17'd1) >= {contours_q, 1'b0};
		cur_inc     = cur_e + 1'b1;
		cur_end     = cur_inc >= total_q;
	end

	// coordinate delta: short with sign, long big-endian, or same
	always_comb begin
		is_y = ph_e == tsgd_pkg::PH_YCOORD;
		sbit = is_y ? |(flag_rd & tsgd_pkg::FLAG_Y_SHORT) : |(flag_rd & tsgd_pkg::FLAG_X_SHORT);
		same = is_y ? |(flag_rd & tsgd_pkg::FLAG_Y_SAME) : |(flag_rd & tsgd_pkg::FLAG_X_SAME);
		acc  = is_y ? yr_e : xr_e;
		need = sbit || !same;
		first_long = !sbit && !same && (fbc_e == 16'd0);
		done = !first_long;
		if (sbit) begin
			dval = same ? (acc + {8'd0, data_byte}) : (acc - {8'd0, data_byte});
		end else if (!same && !first_long) begin
			dval = acc + word;
		end else begin
			dval = acc;
		end
	end

	// next state
	always_comb begin
		phase_d    = ph_e;
		fbc_d      = fbc_e;
		contours_d = contours_q;
		total_d    = total_q;
		skip_d     = skip_q;
		hold_d     = hold_q;
		rep_d      = rep_e;
		rep_flag_d = rep_flag_q;
		cursor_d   = cur_e;
		xr_d       = xr_e;
		yr_d       = yr_e;
		box_d      = box_q;
		do_after   = 1'b0;
		af_cur     = cur_e;
		af_rep     = rep_e;
		unique case (ph_e)
			tsgd_pkg::PH_IDLE: begin
			end
			tsgd_pkg::PH_HEADER: begin
				if (!fbc_e[0]) begin
					hold_d = data_byte;
				end else if (hdr_idx == 3'd0) begin
					contours_d = word;
				end else if (hdr_idx <= 3'd4) begin
					box_d[2'(hdr_idx - 3'd1)] = word;
				end
				if (hdr_bad) begin
					phase_d = tsgd_pkg::PH_IDLE;
				end else if (fbc_e == 16'(tsgd_pkg::HEADER_BYTES - 1)) begin
					fbc_d   = '0;
					phase_d = tsgd_pkg::PH_ENDPTS;
				end else begin
					fbc_d = fbc_e + 16'd1;
				end
			end
			tsgd_pkg::PH_ENDPTS: begin
				if (!fbc_e[0]) begin
					hold_d = data_byte;
					fbc_d  = fbc_e + 16'd1;
				end else if (endpts_last) begin
					if (pts_bad) begin
						phase_d = tsgd_pkg::PH_IDLE;
					end else begin
						total_d = CNT_W'(pts);
						fbc_d   = '0;
						phase_d = tsgd_pkg::PH_INSLEN;
					end
				end else begin
					fbc_d = fbc_e + 16'd1;
				end
			end
			tsgd_pkg::PH_INSLEN: begin
				if (fbc_e == 16'd0) begin
					hold_d = data_byte;
					fbc_d  = 16'd1;
				end else begin
					skip_d   = word;
					fbc_d    = '0;
					cursor_d = '0;
					rep_d    = '0;
					phase_d  = (word != 16'd0) ? tsgd_pkg::PH_SKIP : tsgd_pkg::PH_FLAGS;
				end
			end
			tsgd_pkg::PH_SKIP: begin
				skip_d = skip_q - 16'd1;
				if (skip_q == 16'd1) begin
					phase_d = tsgd_pkg::PH_FLAGS;
				end
			end
			tsgd_pkg::PH_FLAGS: begin
				cursor_d = cur_inc;
				if (|(data_byte & tsgd_pkg::FLAG_REPEAT)) begin
					rep_flag_d = data_byte;
					phase_d    = tsgd_pkg::PH_COUNT;
				end else begin
					do_after = 1'b1;
					af_cur   = cur_inc;
				end
			end
			tsgd_pkg::PH_COUNT: begin
				rep_d    = data_byte;
				do_after = 1'b1;
				af_rep   = data_byte;
			end
			tsgd_pkg::PH_REPEAT: begin
				cursor_d = cur_inc;
				rep_d    = rep_e - 8'd1;
				do_after = 1'b1;
				af_cur   = cur_inc;
				af_rep   = rep_e - 8'd1;
			end
			tsgd_pkg::PH_XCOORD, tsgd_pkg::PH_YCOORD: begin
				if (is_y) begin
					yr_d = dval;
				end else begin
					xr_d = dval;
				end
				if (first_long) begin
					hold_d = data_byte;
					fbc_d  = 16'd1;
				end else if (!sbit && !same) begin
					fbc_d = '0;
				end
				if (done) begin
					cursor_d = cur_inc;
					if (cur_end) begin
						if (is_y) begin
							phase_d = tsgd_pkg::PH_IDLE;
						end else begin
							cursor_d = '0;
							fbc_d    = '0;
							yr_d     = '0;
							phase_d  = tsgd_pkg::PH_YCOORD;
						end
					end
				end
			end
			default: begin
				phase_d = tsgd_pkg::PH_IDLE;
			end
		endcase
		// end of a flag write: more repeats, next flag, or on to x
		if (do_after) begin
			if ((af_rep != 8'd0) && (af_cur < total_q)) begin
				phase_d = tsgd_pkg::PH_REPEAT;
			end else if (af_cur >= total_q) begin
				rep_d    = '0;
				cursor_d = '0;
				fbc_d    = '0;
				xr_d     = '0;
				phase_d  = tsgd_pkg::PH_XCOORD;
			end else begin
				phase_d = tsgd_pkg::PH_FLAGS;
			end
		end
	end

	// outputs and store writes
	always_comb begin
		res            = '0;
		mem.flag_we    = 1'b0;
		mem.x_we       = 1'b0;
		mem.waddr      = cur_e[IDX_W-1:0];
		mem.flag_wdata = data_byte;
		mem.x_wdata    = dval;
		mem.raddr      = go ? cursor_d[IDX_W-1:0] : cursor_q[IDX_W-1:0];
		unique case (ph_e)
			tsgd_pkg::PH_IDLE: begin
			end
			tsgd_pkg::PH_HEADER: begin
				res.byte_taken = 1'b1;
				if (hdr_bad) begin
					res.error_code = tsgd_pkg::ERR_CONTOURS;
				end
			end
			tsgd_pkg::PH_ENDPTS: begin
				res.byte_taken = 1'b1;
				if (fbc_e[0] && endpts_last && pts_bad) begin
					res.error_code = tsgd_pkg::ERR_POINTS;
				end
			end
			tsgd_pkg::PH_INSLEN, tsgd_pkg::PH_SKIP, tsgd_pkg::PH_COUNT: begin
				res.byte_taken = 1'b1;
			end
			tsgd_pkg::PH_FLAGS: begin
				res.byte_taken = 1'b1;
				mem.flag_we    = go && (cur_e < CNT_W'(tsgd_pkg::MAX_POINTS));
			end
			tsgd_pkg::PH_REPEAT: begin
				mem.flag_we    = go && (cur_e < CNT_W'(tsgd_pkg::MAX_POINTS));
				mem.flag_wdata = rep_flag_q;
			end
			tsgd_pkg::PH_XCOORD: begin
				res.byte_taken = need;
				mem.x_we       = go && done && (cur_e < CNT_W'(tsgd_pkg::MAX_POINTS));
			end
			tsgd_pkg::PH_YCOORD: begin
				res.byte_taken = need;
				if (done) begin
					res.point_valid = 1'b1;
					res.point_index = tsgd_pkg::INDEX_W'(cur_e);
					res.x_coord     = x_rd;
					res.y_coord     = dval;
					res.point_flag  = flag_rd;
					if (cur_end) begin
						res.last_point = 1'b1;
						res.box_x_min  = box_q[0];
						res.box_y_min  = box_q[1];
						res.box_x_max  = box_q[2];
						res.box_y_max  = box_q[3];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= tsgd_pkg::PH_IDLE;
			fbc_q      <= '0;
			contours_q <= '0;
			total_q    <= '0;
			skip_q     <= '0;
			hold_q     <= '0;
			rep_q      <= '0;
			rep_flag_q <= '0;
			cursor_q   <= '0;
			xr_q       <= '0;
			yr_q       <= '0;
			for (int i = 0; i < 4; i++) begin
				box_q[i] <= '0;
			end
		end else if (go) begin
			phase_q    <= phase_d;
			fbc_q      <= fbc_d;
			contours_q <= contours_d;
			total_q    <= total_d;
			skip_q     <= skip_d;
			hold_q     <= hold_d;
			rep_q      <= rep_d;
			rep_flag_q <= rep_flag_d;
			cursor_q   <= cursor_d;
			xr_q       <= xr_d;
			yr_q       <= yr_d;
			box_q      <= box_d;
		end
	end

endmodule

/* src/truetype_simple_glyph_decoder.sv */
// simple glyph decoder: walks the bytes of one simple glyph record
// input channel (in_valid/in_ready): one offered glyph byte per item,
//   glyph_start marks the first byte of a glyph and restarts the parse
// output channel (out_valid/out_ready): exactly one result item per input item;
//   byte_taken low tells the feeder to offer the same byte again (flag repeats,
//   same-value coordinates, the high byte of nothing), point_valid marks a point
// path: input register, then parse logic into the result register
// throughput: one item per cycle unless stalled; flag and x stores are
//   single-port-write, single-read rams whose read address is the next point
//   cursor, so the stored flag and x value wait in the read register when needed
// stall: while out_ready is low the result register holds and the input
//   register fills once, then in_ready drops; nothing is lost or repeated
// reset: arst_n clears the parse to idle and all counters; the stores keep
//   whatever they hold, each entry is written in a glyph before it is read
// errors: a contour count of zero or negative gives error 1, more points than
//   the store holds gives error 2, both on the offending byte, then idle
module truetype_simple_glyph_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       glyph_start,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       byte_taken,
	output logic                       point_valid,
	output logic [tsgd_pkg::INDEX_W-1:0] point_index,
	output logic signed [15:0]         x_coord,
	output logic signed [15:0]         y_coord,
	output logic [7:0]                 point_flag,
	output logic                       last_point,
	output logic [1:0]                 error_code,
	output logic signed [15:0]         box_x_min,
	output logic signed [15:0]         box_y_min,
	output logic signed [15:0]         box_x_max,
	output logic signed [15:0]         box_y_max
);

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;

	// result register
	logic              valid_s2;
	tsgd_pkg::result_t res_s2;

	tsgd_pkg::result_t  res;
	tsgd_pkg::mem_ctl_t mem;
	logic [7:0]         flag_rd;
	logic [15:0]        x_rd;
	logic               adv;

	// the held item is parsed when the result register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			start_s1 <= glyph_start;
		end
	end

	tsgd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (adv),
		.data_byte   (data_s1),
		.glyph_start (start_s1),
		.flag_rd     (flag_rd),
		.x_rd        (x_rd),
		.res         (res),
		.mem         (mem)
	);

	// expanded flag per point
	tsgd_ram #(
		.WIDTH (8),
		.DEPTH (tsgd_pkg::MAX_POINTS)
	) u_flag_ram (
		.clk   (clk),
		.we    (mem.flag_we),
		.waddr (mem.waddr),
		.wdata (mem.flag_wdata),
		.raddr (mem.raddr),
		.rdata (flag_rd)
	);

	// absolute x per point, read back during the y pass
	tsgd_ram #(
		.WIDTH (16),
		.DEPTH (tsgd_pkg::MAX_POINTS)
	) u_x_ram (
		.clk   (clk),
		.we    (mem.x_we),
		.waddr (mem.waddr),
		.wdata (mem.x_wdata),
		.raddr (mem.raddr),
		.rdata (x_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign byte_taken  = res_s2.byte_taken;
	assign point_valid = res_s2.point_valid;
	assign point_index = res_s2.point_index;
	assign x_coord     = $signed(res_s2.x_coord);
	assign y_coord     = $signed(res_s2.y_coord);
	assign point_flag  = res_s2.point_flag;
	assign last_point  = res_s2.last_point;
	assign error_code  = res_s2.error_code;
	assign box_x_min   = $signed(res_s2.box_x_min);
	assign box_y_min   = $signed(res_s2.box_y_min);
	assign box_x_max   = $signed(res_s2.box_x_max);
	assign box_y_max   = $signed(res_s2.box_y_max);

endmodule

/* src/tsgd_checker.sv */
`include "truetype_simple_glyph_decoder_assert.svh"

module tsgd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [7:0]                   data_byte,
	input logic                         glyph_start,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         byte_taken,
	input logic                         point_valid,
	input logic [tsgd_pkg::INDEX_W-1:0] point_index,
	input logic [15:0]                  x_coord,
	input logic [15:0]                  y_coord,
	input logic [7:0]                   point_flag,
	input logic                         last_point,
	input logic [1:0]                   error_code,
	input logic [15:0]                  box_x_min,
	input logic [15:0]                  box_y_min,
	input logic [15:0]                  box_x_max,
	input logic [15:0]                  box_y_max
);

	// a stalled result holds
	`TSGD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(byte_taken) && $stable(point_valid) && $stable(point_index) && $stable(x_coord) && $stable(y_coord), "result changed while stalled")

	// point fields are zero without a point
	`TSGD_ASSERT_NOW(a_no_point_zero, out_valid && !point_valid, (point_index == '0) && (x_coord == 16'd0) && (y_coord == 16'd0) && (point_flag == 8'd0) && !last_point, "point fields set without a point")

	// box only rides on the last point
	`TSGD_ASSERT_NOW(a_box_last, out_valid && !last_point, (box_x_min == 16'd0) && (box_y_min == 16'd0) && (box_x_max == 16'd0) && (box_y_max == 16'd0), "box given off the last point")

	// an error consumes its byte and carries no point
	`TSGD_ASSERT_NOW(a_error_item, out_valid && (error_code != tsgd_pkg::ERR_NONE), byte_taken && !point_valid, "error item malformed")

endmodule

bind truetype_simple_glyph_decoder tsgd_checker u_tsgd_checker (.*);

/* dv/truetype_simple_glyph_decoder_tb.sv */
module truetype_simple_glyph_decoder_tb;
	import tsgd_pkg::*;

	// cycles with no handshake on either side before the run is declared hung
	localparam int QUIET_LIMIT  = 1500;
	// settle time after the last prediction is answered, before the verdict
	localparam int DRAIN_CYCLES = 8;
	// one long receiver hold-off so the decoder fills up and drops in_ready
	localparam int HOLD_CYCLES  = 250;
	localparam int HOLD_AFTER   = 150;
	localparam int MAX_WAIT     = 17;
	// stop generating random glyphs once this many bytes are queued
	localparam int FEED_TARGET  = 1300;

	// one entry of the byte stream handed to the feeder
	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} glyph_byte_t;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic [7:0]          data_byte   = 8'h00;
	logic                glyph_start = 1'b0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic                byte_taken;
	logic                point_valid;
	logic [INDEX_W-1:0]  point_index;
	logic signed [15:0]  x_coord;
	logic signed [15:0]  y_coord;
	logic [7:0]          point_flag;
	logic                last_point;
	logic [1:0]          error_code;
	logic signed [15:0]  box_x_min;
	logic signed [15:0]  box_y_min;
	logic signed [15:0]  box_x_max;
	logic signed [15:0]  box_y_max;

	truetype_simple_glyph_decoder dut (.*);

	// glyph bytes still to be fed, head is the one on the bus
	glyph_byte_t glyph_bytes[$];
	// decoder results predicted for accepted items, oldest first
	result_t     results_due[$];

	int fault_count  = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	int hold_left    = 0;
	bit hold_used    = 1'b0;
	int tx_wait      = 0;
	int rx_wait      = 0;
	bit tx_idling    = 1'b1;
	bit rx_idling    = 1'b1;

	// shadow decoder state
	phase_t      dec_phase;
	int unsigned dec_byte_cnt;
	int unsigned dec_contours;
	int unsigned dec_points;
	int unsigned dec_cursor;
	logic [15:0] dec_skip_left;
	logic [15:0] dec_x_acc;
	logic [15:0] dec_y_acc;
	logic [7:0]  dec_hi_byte;
	logic [7:0]  dec_rep_left;
	logic [7:0]  dec_rep_flag;
	logic [7:0]  dec_flag_mem [MAX_POINTS];
	logic [15:0] dec_x_mem [MAX_POINTS];
	logic [15:0] dec_box [4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stores are left alone, every entry is written before it is read
	task automatic reset_decoder_model();
		dec_phase     = PH_IDLE;
		dec_byte_cnt  = 0;
		dec_contours  = 0;
		dec_points    = 0;
		dec_cursor    = 0;
		dec_skip_left = '0;
		dec_x_acc     = '0;
		dec_y_acc     = '0;
		dec_hi_byte   = '0;
		dec_rep_left  = '0;
		dec_rep_flag  = '0;
		foreach (dec_box[i])
			dec_box[i] = '0;
	endtask

	// one coordinate step: short byte with sign from the same bit, long
	// big-endian word over two items, or no byte at all for a repeated value
	function automatic logic [15:0] apply_coord_delta(input logic [15:0] acc,
			input logic [7:0] f, input logic [7:0] short_bit,
			input logic [7:0] same_bit, input logic [7:0] b,
			output logic need, output logic done);
		need = 1'b0;
		done = 1'b1;
		if ((f & short_bit) != 0) begin
			need = 1'b1;
			if ((f & same_bit) != 0)
				return acc + 16'(b);
			return acc - 16'(b);
		end
		if ((f & same_bit) == 0) begin
			need = 1'b1;
			if (dec_byte_cnt == 0) begin
				dec_hi_byte  = b;
				dec_byte_cnt = 1;
				done         = 1'b0;
				return acc;
			end
			dec_byte_cnt = 0;
			return acc + {dec_hi_byte, b};
		end
		return acc;
	endfunction

	// after a flag lands in the store: more repeats, next flag, or on to x
	function automatic void advance_flag_cursor();
		if (dec_rep_left != 0 && dec_cursor < dec_points) begin
			dec_phase = PH_REPEAT;
		end else if (dec_cursor >= dec_points) begin
			dec_rep_left = '0;
			dec_cursor   = 0;
			dec_byte_cnt = 0;
			dec_x_acc    = '0;
			dec_phase    = PH_XCOORD;
		end else begin
			dec_phase = PH_FLAGS;
		end
	endfunction

	// expected result of one offered byte, advancing the shadow state
	function automatic result_t decode_glyph_byte(input logic [7:0] b, input logic start);
		result_t     r;
		logic [15:0] word;
		logic [16:0] count;
		logic [7:0]  f;
		logic        need;
		logic        done;
		int unsigned idx;
		r = '0;
		if (start) begin
			dec_phase    = PH_HEADER;
			dec_byte_cnt = 0;
			dec_cursor   = 0;
			dec_rep_left = '0;
			dec_x_acc    = '0;
			dec_y_acc    = '0;
		end
		case (dec_phase)
			PH_HEADER: begin
				r.byte_taken = 1'b1;
				if (dec_byte_cnt % 2 == 0) begin
					dec_hi_byte = b;
				end else begin
					word = {dec_hi_byte, b};
					idx  = dec_byte_cnt >> 1;
					if (idx == 0) begin
						dec_contours = word;
						if (word == 0 || word[15]) begin
							r.error_code = ERR_CONTOURS;
							dec_phase    = PH_IDLE;
							return r;
						end
					end else if (idx <= 4) begin
						dec_box[idx-1] = word;
					end
				end
				dec_byte_cnt++;
				if (dec_byte_cnt >= HEADER_BYTES) begin
					dec_byte_cnt = 0;
					dec_phase    = PH_ENDPTS;
				end
			end
			PH_ENDPTS: begin
				r.byte_taken = 1'b1;
				if (dec_byte_cnt % 2 == 0) begin
					dec_hi_byte = b;
					dec_byte_cnt++;
				end else if (dec_byte_cnt + 1 >= 2 * dec_contours) begin
					// only the last end point counts
					count = {1'b0, dec_hi_byte, b} + 17'd1;
					if (count > MAX_POINTS) begin
						r.error_code = ERR_POINTS;
						dec_phase    = PH_IDLE;
						return r;
					end
					dec_points   = count;
					dec_byte_cnt = 0;
					dec_phase    = PH_INSLEN;
				end else begin
					dec_byte_cnt++;
				end
			end
			PH_INSLEN: begin
				r.byte_taken = 1'b1;
				if (dec_byte_cnt == 0) begin
					dec_hi_byte  = b;
					dec_byte_cnt = 1;
				end else begin
					dec_skip_left = {dec_hi_byte, b};
					dec_byte_cnt  = 0;
					dec_cursor    = 0;
					dec_rep_left  = '0;
					if (dec_skip_left != 0)
						dec_phase = PH_SKIP;
					else
						dec_phase = PH_FLAGS;
				end
			end
			PH_SKIP: begin
				r.byte_taken = 1'b1;
				dec_skip_left--;
				if (dec_skip_left == 0)
					dec_phase = PH_FLAGS;
			end
			PH_FLAGS: begin
				r.byte_taken = 1'b1;
				if (dec_cursor < MAX_POINTS)
					dec_flag_mem[dec_cursor] = b;
				dec_cursor++;
				if ((b & FLAG_REPEAT) != 0) begin
					dec_rep_flag = b;
					dec_phase    = PH_COUNT;
				end else begin
					advance_flag_cursor();
				end
			end
			PH_COUNT: begin
				r.byte_taken = 1'b1;
				dec_rep_left = b;
				advance_flag_cursor();
			end
			PH_REPEAT: begin
				if (dec_cursor < MAX_POINTS)
					dec_flag_mem[dec_cursor] = dec_rep_flag;
				dec_cursor++;
				dec_rep_left--;
				advance_flag_cursor();
			end
			PH_XCOORD: begin
				f = (dec_cursor < MAX_POINTS) ? dec_flag_mem[dec_cursor] : 8'h00;
				dec_x_acc = apply_coord_delta(dec_x_acc, f, FLAG_X_SHORT, FLAG_X_SAME,
					b, need, done);
				r.byte_taken = need;
				if (done) begin
					if (dec_cursor < MAX_POINTS)
						dec_x_mem[dec_cursor] = dec_x_acc;
					dec_cursor++;
					if (dec_cursor >= dec_points) begin
						dec_cursor   = 0;
						dec_byte_cnt = 0;
						dec_y_acc    = '0;
						dec_phase    = PH_YCOORD;
					end
				end
			end
			PH_YCOORD: begin
				f = (dec_cursor < MAX_POINTS) ? dec_flag_mem[dec_cursor] : 8'h00;
				dec_y_acc = apply_coord_delta(dec_y_acc, f, FLAG_Y_SHORT, FLAG_Y_SAME,
					b, need, done);
				r.byte_taken = need;
				if (done) begin
					r.point_valid = 1'b1;
					r.point_index = INDEX_W'(dec_cursor);
					r.x_coord     = (dec_cursor < MAX_POINTS) ? dec_x_mem[dec_cursor] : 16'h0;
					r.y_coord     = dec_y_acc;
					r.point_flag  = f;
					dec_cursor++;
					if (dec_cursor >= dec_points) begin
						r.last_point = 1'b1;
						r.box_x_min  = dec_box[0];
						r.box_y_min  = dec_box[1];
						r.box_x_max  = dec_box[2];
						r.box_y_max  = dec_box[3];
						dec_phase    = PH_IDLE;
					end
				end
			end
			default: begin
				// idle: nothing happens until a glyph start
			end
		endcase
		return r;
	endfunction

	function automatic int draw_wait(input bit idling);
		return idling ? int'($urandom_range(0, MAX_WAIT)) : 0;
	endfunction

	task automatic add_byte(input logic [7:0] b, input logic st);
		glyph_byte_t e;
		e.data  = b;
		e.start = st;
		glyph_bytes.push_back(e);
	endtask

	task automatic add_word(ref logic [7:0] q[$], input logic [15:0] w);
		q.push_back(w[15:8]);
		q.push_back(w[7:0]);
	endtask

	// first keep bytes of a glyph, glyph start on the first one
	task automatic queue_stream(ref logic [7:0] body[$], input int keep);
		int k;
		for (k = 0; k < keep; k++)
			add_byte(body[k], k == 0);
	endtask

	// a well-formed simple glyph with random content, optionally cut short;
	// bulk gives long repeat runs with repeated coordinates for big glyphs
	task automatic queue_glyph(input int n_pts, input bit chop, input bit bulk);
		logic [7:0] body[$];
		logic [7:0] pt_flag[$];
		logic [7:0] f;
		logic [7:0] rep;
		int         contours;
		int         ins_len;
		int         keep;
		int         i;
		int         k;
		contours = bulk ? 1 : int'($urandom_range(1, 3));
		add_word(body, 16'(contours));
		repeat (4)
			add_word(body, 16'($urandom));
		for (i = 1; i < contours; i++)
			add_word(body, 16'($urandom_range(0, n_pts - 1)));
		add_word(body, 16'(n_pts - 1));
		ins_len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(3, 20))
			: int'($urandom_range(0, 2));
		add_word(body, 16'(ins_len));
		repeat (ins_len)
			body.push_back(8'($urandom));
		while (pt_flag.size() < n_pts) begin
			f = 8'($urandom);
			if (bulk)
				f = (f & ~(FLAG_X_SHORT | FLAG_Y_SHORT)) | FLAG_X_SAME | FLAG_Y_SAME
					| FLAG_REPEAT;
			else if ($urandom_range(0, 2) != 0)
				f = f & ~FLAG_REPEAT;
			body.push_back(f);
			pt_flag.push_back(f);
			if ((f & FLAG_REPEAT) != 0) begin
				// counts past the last point get clipped by the decoder
				if (bulk)
					rep = 8'($urandom_range(100, 255));
				else if ($urandom_range(0, 4) == 0)
					rep = 8'($urandom);
				else
					rep = 8'($urandom_range(0, 3));
				body.push_back(rep);
				for (k = 0; k < rep && pt_flag.size() < n_pts; k++)
					pt_flag.push_back(f);
			end
		end
		foreach (pt_flag[j]) begin
			if ((pt_flag[j] & FLAG_X_SHORT) != 0)
				body.push_back(8'($urandom));
			else if ((pt_flag[j] & FLAG_X_SAME) == 0)
				add_word(body, 16'($urandom));
		end
		foreach (pt_flag[j]) begin
			if ((pt_flag[j] & FLAG_Y_SHORT) != 0)
				body.push_back(8'($urandom));
			else if ((pt_flag[j] & FLAG_Y_SAME) == 0)
				add_word(body, 16'($urandom));
		end
		keep = chop ? int'($urandom_range(1, body.size() - 1)) : body.size();
		queue_stream(body, keep);
		// trailing byte without glyph start so byteless final points can emit
		add_byte(8'($urandom), 1'b0);
	endtask

	// header that ends in an error: bad contour count or too many points
	task automatic queue_bad_header(input bit too_many);
		logic [7:0] body[$];
		if (too_many) begin
			add_word(body, 16'd1);
			repeat (4)
				add_word(body, 16'($urandom));
			add_word(body, 16'($urandom_range(MAX_POINTS, 65535)));
		end else if ($urandom_range(0, 1) == 0) begin
			add_word(body, 16'd0);
		end else begin
			add_word(body, 16'h8000 | 16'($urandom));
		end
		queue_stream(body, body.size());
	endtask

	// feeder: offers the head byte; a byte the decoder did not take stays at
	// the head and is offered again, unless the parser has gone idle
	always @(posedge clk) begin : feeder
		result_t due;
		int      wait_n;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			data_byte   <= 8'h00;
			glyph_start <= 1'b0;
			tx_wait     <= 0;
		end else begin
			wait_n = tx_wait;
			if (in_valid && in_ready) begin
				due = decode_glyph_byte(data_byte, glyph_start);
				results_due.push_back(due);
				if (due.byte_taken || dec_phase == PH_IDLE)
					void'(glyph_bytes.pop_front());
				// switch now and then between gappy and back-to-back stretches
				if ($urandom_range(0, 39) == 0)
					tx_idling = !tx_idling;
				wait_n = draw_wait(tx_idling);
			end else if (!in_valid && wait_n > 0) begin
				wait_n--;
			end
			if (in_valid && !in_ready) begin
				// hold the item until it is accepted
			end else if (wait_n == 0 && glyph_bytes.size() != 0) begin
				in_valid    <= 1'b1;
				data_byte   <= glyph_bytes[0].data;
				glyph_start <= glyph_bytes[0].start;
			end else begin
				in_valid <= 1'b0;
			end
			tx_wait <= wait_n;
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			if (fault_count < 10)
				$display("result %0d: %s expected %h got %h", results_seen, name, want, got);
			fault_count++;
		end
	endtask

	// receiver: checks every result item against the oldest prediction and
	// stalls at random; the long hold-off below also gates out_ready
	always @(posedge clk) begin : receiver
		result_t want;
		int      wait_n;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait   <= 0;
		end else begin
			wait_n = rx_wait;
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					if (fault_count < 10)
						$display("result %0d: arrived with nothing predicted", results_seen);
					fault_count++;
				end else begin
					want = results_due.pop_front();
					check_field("byte_taken", want.byte_taken, byte_taken);
					check_field("point_valid", want.point_valid, point_valid);
					check_field("point_index", want.point_index, point_index);
					check_field("x_coord", want.x_coord, x_coord);
					check_field("y_coord", want.y_coord, y_coord);
					check_field("point_flag", want.point_flag, point_flag);
					check_field("last_point", want.last_point, last_point);
					check_field("error_code", want.error_code, error_code);
					check_field("box_x_min", want.box_x_min, box_x_min);
					check_field("box_y_min", want.box_y_min, box_y_min);
					check_field("box_x_max", want.box_x_max, box_x_max);
					check_field("box_y_max", want.box_y_max, box_y_max);
				end
				results_seen <= results_seen + 1;
				if ($urandom_range(0, 39) == 0)
					rx_idling = !rx_idling;
				wait_n = draw_wait(rx_idling);
			end else if (!out_ready && wait_n > 0) begin
				wait_n--;
			end
			rx_wait   <= wait_n;
			out_ready <= (wait_n == 0) && (hold_left == 0);
		end
	end

	// one long hold-off on the result side while the feeder keeps offering
	always @(posedge clk) begin : backpressure
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_used && results_seen >= HOLD_AFTER) begin
				hold_left <= HOLD_CYCLES;
				hold_used <= 1'b1;
			end
		end
	end

	// hang detection: no item moving on either side for too long
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [7:0] body[$];
		int         pick;
		bit         big_done;
		big_done = 1'b0;
		reset_decoder_model();

		// bytes with no glyph start while idle are ignored
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		// zero and negative contour counts
		body = {8'h00, 8'h00};
		queue_stream(body, body.size());
		body = {8'h80, 8'h00};
		queue_stream(body, body.size());
		// extreme bounding box, then one point more than the stores hold
		body = {8'h00, 8'h01, 8'h80, 8'h00, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h7F, 8'hFF,
			8'h02, 8'h00};
		queue_stream(body, body.size());
		// one-point glyph whose repeat count runs past the point count,
		// both coordinates repeated so the point comes out without a byte
		body = {8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h12, 8'h34, 8'h7F, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h39, 8'h05};
		queue_stream(body, body.size());
		add_byte(8'h5A, 1'b0);

		// random glyphs: mostly well formed and small, some cut short, some
		// with bad headers, a little noise, and one glyph filling the stores
		while (glyph_bytes.size() < FEED_TARGET) begin
			if (!big_done && glyph_bytes.size() > FEED_TARGET / 2) begin
				queue_glyph(MAX_POINTS, 1'b0, 1'b1);
				big_done = 1'b1;
			end
			pick = $urandom_range(0, 19);
			if (pick < 15)
				queue_glyph(($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 60))
					: int'($urandom_range(1, 12)), 1'b0, 1'b0);
			else if (pick < 17)
				queue_glyph($urandom_range(1, 12), 1'b1, 1'b0);
			else if (pick < 19)
				queue_bad_header($urandom_range(0, 1));
			else
				repeat ($urandom_range(1, 4))
					add_byte(8'($urandom), 1'b0);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// everything fed and every prediction answered
		while (glyph_bytes.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
